FILE: design/huffman_code_builder_top_assert.svh
// Assertion macros used by the Huffman code builder sequencer.
`ifndef HUFFMAN_CODE_BUILDER_TOP_ASSERT_SVH
`define HUFFMAN_CODE_BUILDER_TOP_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define HCB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define HCB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/hcb_pkg.sv
//------------------------------------------------------------------------------
// hcb_pkg
// Shared constants and control/status types of the Huffman code builder.
//------------------------------------------------------------------------------
`default_nettype none

package hcb_pkg;

    localparam int MAX_SYMBOLS_DEF = 32;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int IN_WEIGHT_W     = 16;
    localparam int IDX_W           = 6;
    localparam int CODE_W          = 63;
    localparam int LEN_W           = 6;

    // Controller commands to the datapath.
    typedef struct packed {
        logic load;       // store incoming weight
        logic init;       // mark leaves live, start build
        logic scan_clr;   // clear scan bests
        logic scan_step;  // compare one node
        logic merge;      // form parent from the two bests
        logic code_step;  // push codes from one inner node to its children
        logic out_step;   // advance output index
        logic done_clr;   // end of set
    } t_hcb_cmd;

    // Datapath status to the controller.
    typedef struct packed {
        logic last_node;   // scan index at last node so far
        logic build_done;  // all merges done
        logic code_done;   // all inner nodes pushed
        logic out_last;    // output index at last symbol
    } t_hcb_sts;

endpackage

`default_nettype wire

FILE: design/hcb_if.sv
//------------------------------------------------------------------------------
// hcb_in_if / hcb_out_if
// Valid/ready channels of the Huffman code builder.
//------------------------------------------------------------------------------
`default_nettype none

interface hcb_in_if;
    import hcb_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [IN_WEIGHT_W-1:0] weight;
    logic                   last;
    modport source (output valid, weight, last, input ready);
    modport sink   (input valid, weight, last, output ready);
endinterface

interface hcb_out_if;
    import hcb_pkg::*;
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  symbol_index;
    logic [15:0]       symbol_weight;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic              final_result;
    modport source (output valid, symbol_index, symbol_weight, code_bits, code_length,
                    final_result, input ready);
    modport sink   (input valid, symbol_index, symbol_weight, code_bits, code_length,
                    final_result, output ready);
endinterface

`default_nettype wire

FILE: design/hcb_ctrl.sv
//------------------------------------------------------------------------------
// hcb_ctrl
// Sequencer: load, scan/merge loop, code push-down, result drain.
//------------------------------------------------------------------------------
`default_nettype none

`include "huffman_code_builder_top_assert.svh"

module hcb_ctrl
    import hcb_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_in_last,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_hcb_cmd      o_cmd,
    input  wire t_hcb_sts i_sts
);

    typedef enum logic [2:0] {
        S_LOAD, S_INIT, S_SCAN_A, S_SCAN_B, S_MERGE, S_CODE, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   in_xfer, out_xfer;

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = (r_state == S_OUT);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_xfer    = o_out_valid && i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_LOAD: begin
                if (in_xfer) begin
                    o_cmd.load = 1'b1;
                    if (i_in_last) n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.init     = 1'b1;
                o_cmd.scan_clr = 1'b1;
                n_state        = S_SCAN_A;
            end
            S_SCAN_A: begin
                if (i_sts.build_done) begin
                    n_state = S_CODE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    if (i_sts.last_node) n_state = S_MERGE;
                end
            end
            S_SCAN_B: n_state = S_SCAN_A;
            S_MERGE: begin
                o_cmd.merge    = 1'b1;
                o_cmd.scan_clr = 1'b1;
                n_state        = S_SCAN_A;
            end
            S_CODE: begin
                if (i_sts.code_done) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.code_step = 1'b1;
                end
            end
            S_OUT: begin
                if (out_xfer) begin
                    o_cmd.out_step = 1'b1;
                    if (i_sts.out_last) begin
                        o_cmd.done_clr = 1'b1;
                        n_state        = S_LOAD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    `HCB_ASSERT_IMP(a_no_in_out_overlap, i_clk, i_rst_n, o_out_valid, !o_in_ready,
        "input ready while results pending")
    `HCB_ASSERT_NEXT(a_last_starts_build, i_clk, i_rst_n, in_xfer && i_in_last,
        r_state == S_INIT, "last transfer did not start build")
    `HCB_ASSERT_NEXT(a_merge_rescans, i_clk, i_rst_n, o_cmd.merge,
        r_state == S_SCAN_A, "merge not followed by scan")

endmodule

`default_nettype wire

FILE: design/hcb_dp.sv
//------------------------------------------------------------------------------
// hcb_dp
// Leaf and inner-node tables, liveness, children, codes; one node compared per cycle while scanning.
//------------------------------------------------------------------------------
`default_nettype none

module hcb_dp
    import hcb_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
)(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_hcb_cmd               i_cmd,
    output t_hcb_sts                    o_sts,
    input  wire logic [IN_WEIGHT_W-1:0] i_weight,
    output logic [IDX_W-1:0]            o_symbol_index,
    output logic [15:0]                 o_symbol_weight,
    output logic [CODE_W-1:0]           o_code_bits,
    output logic [LEN_W-1:0]            o_code_length,
    output logic                        o_final_result
);

    localparam int NODES = 2 * MAX_SYMBOLS - 1;
    localparam int INNER = (MAX_SYMBOLS > 1) ? MAX_SYMBOLS - 1 : 1;
    localparam int NID_W = $clog2(NODES + 1);
    localparam int LI_W  = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int II_W  = (INNER > 1) ? $clog2(INNER) : 1;
    localparam int NW_W  = WEIGHT_BITS + $clog2(MAX_SYMBOLS + 1);
    localparam int CB_W  = INNER;
    localparam int CL_W  = $clog2(MAX_SYMBOLS + 1);

    // Node ids: leaves 0..n-1 live in the leaf tables, merged nodes n.. in the inner tables.
    logic [15:0]       r_lw   [MAX_SYMBOLS];
    logic [NW_W-1:0]   r_iw   [INNER];
    logic [NID_W-1:0]  r_left [INNER];
    logic [NID_W-1:0]  r_right[INNER];
    logic [CB_W-1:0]   r_lcode[MAX_SYMBOLS];
    logic [CB_W-1:0]   r_icode[INNER];
    logic [CL_W-1:0]   r_llen [MAX_SYMBOLS];
    logic [CL_W-1:0]   r_ilen [INNER];
    logic [NODES-1:0]  r_alive, n_alive;
    logic [NID_W-1:0]  r_n, r_total, r_scan, r_code_idx, r_out;
    logic [NID_W-1:0]  r_a, r_b;
    logic [NW_W-1:0]   r_wa, r_wb;
    logic              r_a_ok, r_b_ok;

    // Merge-order compare of node x against node y.
    function automatic logic first(input logic [NID_W-1:0] x, input logic [NID_W-1:0] y,
                                   input logic [NW_W-1:0] wx, input logic [NW_W-1:0] wy,
                                   input logic [NID_W-1:0] n);
        logic xl, yl;
        xl = x < n;
        yl = y < n;
        if (wx != wy) return wx < wy;
        if (xl != yl) return xl;
        if (xl) return x > y;
        return x < y;
    endfunction

    logic [NW_W-1:0]  w_s;
    logic             s_live, s_vs_a, s_vs_b;
    logic [NID_W-1:0] hi, lo, p_node, p_left, p_right;
    logic [II_W-1:0]  s_ii, m_ii, p_ii, root_ii;
    logic [CB_W-1:0]  p_code;
    logic [CL_W-1:0]  p_len;
    logic [15:0]      wmask;

    assign s_ii    = II_W'(r_scan - r_n);
    assign w_s     = (r_scan < r_n) ? NW_W'(r_lw[r_scan[LI_W-1:0]]) : r_iw[s_ii];
    assign s_live  = r_alive[r_scan];
    assign s_vs_a  = !r_a_ok || first(r_scan, r_a, w_s, r_wa, r_n);
    assign s_vs_b  = !r_b_ok || first(r_scan, r_b, w_s, r_wb, r_n);
    assign hi      = (r_wa < r_wb || (r_wa == r_wb && r_a > r_b)) ? r_b : r_a;
    assign lo      = (hi == r_a) ? r_b : r_a;
    assign m_ii    = II_W'(r_total - r_n);
    assign root_ii = II_W'(r_n - 2'd2);
    assign p_node  = r_code_idx - 1'b1;
    assign p_ii    = II_W'(p_node - r_n);
    assign p_left  = r_left[p_ii];
    assign p_right = r_right[p_ii];
    assign p_code  = r_icode[p_ii];
    assign p_len   = r_ilen[p_ii];
    assign wmask   = 16'((17'd1 << ((WEIGHT_BITS < 16) ? WEIGHT_BITS : 16)) - 17'd1);

    assign o_sts.last_node  = (r_scan == r_total - 1'b1);
    assign o_sts.build_done = ({1'b0, r_total} >= {r_n, 1'b0} - 1'b1);
    assign o_sts.code_done  = (r_code_idx <= r_n) || (r_code_idx == '0);
    assign o_sts.out_last   = (r_out == r_n - 1'b1);

    always_comb begin
        n_alive = r_alive;
        if (i_cmd.init) begin
            for (int i = 0; i < NODES; i++) n_alive[i] = (NID_W'(i) < r_n);
        end
        if (i_cmd.merge) begin
            n_alive[r_a]     = 1'b0;
            n_alive[r_b]     = 1'b0;
            n_alive[r_total] = 1'b1;
        end
        if (i_cmd.done_clr) n_alive = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n     <= '0;
            r_alive <= '0;
            r_out   <= '0;
        end else begin
            r_alive <= n_alive;
            if (i_cmd.done_clr) begin
                r_n <= '0;
            end else if (i_cmd.load && r_n < NID_W'(MAX_SYMBOLS)) begin
                r_lw[r_n[LI_W-1:0]] <= i_weight & wmask;
                r_n <= r_n + 1'b1;
            end
            if (i_cmd.init) begin
                r_total    <= r_n;
                r_code_idx <= (r_n << 1) - 1'b1;
                // Root starts with an empty code; a lone leaf is its own root.
                r_lcode[0] <= '0;
                r_llen[0]  <= '0;
                if (r_n > NID_W'(1)) begin
                    r_icode[root_ii] <= '0;
                    r_ilen[root_ii]  <= '0;
                end
            end else if (i_cmd.merge) begin
                r_iw[m_ii]    <= r_wa + r_wb;
                r_left[m_ii]  <= hi;
                r_right[m_ii] <= lo;
                r_total       <= r_total + 1'b1;
            end else if (i_cmd.code_step) begin
                if (p_left < r_n) begin
                    r_lcode[p_left[LI_W-1:0]] <= p_code << 1;
                    r_llen[p_left[LI_W-1:0]]  <= p_len + 1'b1;
                end else begin
                    r_icode[II_W'(p_left - r_n)] <= p_code << 1;
                    r_ilen[II_W'(p_left - r_n)]  <= p_len + 1'b1;
                end
                if (p_right < r_n) begin
                    r_lcode[p_right[LI_W-1:0]] <= (p_code << 1) | CB_W'(1);
                    r_llen[p_right[LI_W-1:0]]  <= p_len + 1'b1;
                end else begin
                    r_icode[II_W'(p_right - r_n)] <= (p_code << 1) | CB_W'(1);
                    r_ilen[II_W'(p_right - r_n)]  <= p_len + 1'b1;
                end
                r_code_idx <= r_code_idx - 1'b1;
            end
            if (i_cmd.scan_clr) begin
                r_scan <= '0;
                r_a_ok <= 1'b0;
                r_b_ok <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_scan <= r_scan + 1'b1;
                if (s_live) begin
                    if (s_vs_a) begin
                        r_a <= r_scan; r_wa <= w_s; r_a_ok <= 1'b1;
                        r_b <= r_a;    r_wb <= r_wa; r_b_ok <= r_a_ok;
                    end else if (s_vs_b) begin
                        r_b <= r_scan; r_wb <= w_s; r_b_ok <= 1'b1;
                    end
                end
            end
            if (i_cmd.done_clr) begin
                r_out <= '0;
            end else if (i_cmd.out_step) begin
                r_out <= r_out + 1'b1;
            end
        end
    end

    assign o_symbol_index  = IDX_W'(r_out);
    assign o_symbol_weight = r_lw[r_out[LI_W-1:0]];
    assign o_code_bits     = CODE_W'(r_lcode[r_out[LI_W-1:0]]);
    assign o_code_length   = LEN_W'(r_llen[r_out[LI_W-1:0]]);
    assign o_final_result  = o_sts.out_last;

endmodule

`default_nettype wire

FILE: design/huffman_code_builder_top.sv
// After the last transfer: an init step; a scan of all nodes so far and a merge step
//   for each merge; an end-of-build check; a code push-down from each inner node, root
//   first; an end check; then one result per cycle while o_out.ready is high.
// Throughput: one weight per cycle while loading; input is held off from the last
//   transfer until the final result transfers, so the merge scan sets the set rate.
// Reset: synchronous active-low i_rst_n clears symbol count, liveness and sequencer.
//------------------------------------------------------------------------------
// huffman_code_builder_top
// Huffman code builder: loads weights, builds tree, emits one code per symbol.
//------------------------------------------------------------------------------
`default_nettype none

module huffman_code_builder_top
    import hcb_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
)(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hcb_in_if.sink    i_in,
    hcb_out_if.source o_out
);

    t_hcb_cmd cmd;
    t_hcb_sts sts;

    hcb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.last),
        .o_in_ready (i_in.ready),
        .o_out_valid(o_out.valid),
        .i_out_ready(o_out.ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    hcb_dp #(.MAX_SYMBOLS(MAX_SYMBOLS), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_weight       (i_in.weight),
        .o_symbol_index (o_out.symbol_index),
        .o_symbol_weight(o_out.symbol_weight),
        .o_code_bits    (o_out.code_bits),
        .o_code_length  (o_out.code_length),
        .o_final_result (o_out.final_result)
    );

endmodule

`default_nettype wire
